### src/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int PULSE_W = 32;
    localparam int FEED_W  = 16;
    localparam int SPM_W   = 16;
    localparam int CNT_W   = 26;
    localparam int PROD_W  = FEED_W + SPM_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Request modes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BWD  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_INV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ENABLE    = 2'd2;

    localparam logic [SPM_W-1:0] SPM_RESET = 16'd80;

    // Divider iterations: one quotient bit per cycle.
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic tick;      // advance the step timer
        logic report;    // report the current state only
        logic move;      // latch a move request
        logic fwd;       // direction of the latched move
        logic mul;       // form the divisor and seed the divider
        logic div_step;  // one restoring division step
        logic finish;    // store the period and present the result
    } t_cmd;

endpackage

`default_nettype wire

### src/ssp_in_if.sv
`default_nettype none

interface ssp_in_if
    import ssp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PULSE_W-1:0]  pulse_count;
    logic [FEED_W-1:0]   feed_rate;

    modport source (output valid, output mode, output pulse_count, output feed_rate,
                    input ready);
    modport sink   (input valid, input mode, input pulse_count, input feed_rate,
                    output ready);
endinterface

`default_nettype wire

### src/ssp_out_if.sv
`default_nettype none

interface ssp_out_if;
    logic valid;
    logic ready;
    logic step_strobe;
    logic direction_level;
    logic moving;
    logic enable_low;

    modport source (output valid, output step_strobe, output direction_level,
                    output moving, output enable_low, input ready);
    modport sink   (input valid, input step_strobe, input direction_level,
                    input moving, input enable_low, output ready);
endinterface

`default_nettype wire

### src/ssp_ctrl.sv
`default_nettype none

module ssp_ctrl
    import ssp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output t_cmd                   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 out_load;

    // Idle takes a request once the result register is free or being emptied.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_TICK: o_cmd.tick = 1'b1;
                        MODE_FWD: begin
                            o_cmd.move = 1'b1;
                            o_cmd.fwd  = 1'b1;
                            n_state    = ST_MUL;
                        end
                        MODE_BWD: begin
                            o_cmd.move = 1'b1;
                            n_state    = ST_MUL;
                        end
                        default: o_cmd.report = 1'b1;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign out_load = o_cmd.tick || o_cmd.report || o_cmd.finish;

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### src/ssp_datapath.sv
`default_nettype none

module ssp_datapath
    import ssp_pkg::*;
#(
    parameter int PERIOD_NUMERATOR = 60000000
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [PULSE_W-1:0]    i_pulse_count,
    input  wire logic [FEED_W-1:0]     i_feed_rate,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_step_strobe,
    output logic                       o_direction_level,
    output logic                       o_moving,
    output logic                       o_enable_low
);

    localparam logic [CNT_W-1:0] NUM = CNT_W'(PERIOD_NUMERATOR);

    // Configuration
    logic [SPM_W-1:0] r_spm;
    logic             r_dir_inv;
    logic             r_motor_en;

    // Motion state
    logic               r_busy, n_busy;
    logic [PULSE_W-1:0] r_pulses, n_pulses;
    logic [CNT_W-1:0]   r_period, n_period;
    logic [CNT_W-1:0]   r_ticks, n_ticks;
    logic               r_dir, n_dir;

    // Divider
    logic [FEED_W-1:0] r_feed;
    logic [PROD_W-1:0] r_divisor;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_quo, n_quo;
    logic [PROD_W:0]   shifted;

    // Result register
    logic r_res_strobe, r_res_dir, r_res_busy, r_res_en_low;

    logic [CNT_W-1:0] ticks_inc;
    logic             active;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm      <= SPM_RESET;
            r_dir_inv  <= 1'b0;
            r_motor_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEPS_PER_MM:  r_spm      <= i_cfg_data;
                CFG_DIRECTION_INV: r_dir_inv  <= i_cfg_data[0];
                CFG_MOTOR_ENABLE:  r_motor_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The elapsed counter is incremented before it is compared with the period.
    assign ticks_inc = (r_ticks == CNT_MAX) ? r_ticks : r_ticks + 1'b1;
    assign active    = r_busy && (r_pulses != '0);
    assign hit       = active && (ticks_inc >= r_period);

    always_comb begin
        n_busy   = r_busy;
        n_pulses = r_pulses;
        n_period = r_period;
        n_ticks  = r_ticks;
        n_dir    = r_dir;
        if (i_cmd.tick) begin
            n_busy   = active;
            n_ticks  = hit ? '0 : ticks_inc;
            n_pulses = hit ? r_pulses - 1'b1 : r_pulses;
        end
        if (i_cmd.move) begin
            n_dir    = i_cmd.fwd ^ r_dir_inv;
            n_pulses = i_pulse_count;
            n_busy   = 1'b1;
        end
        if (i_cmd.finish) begin
            n_period = (r_divisor == '0) ? CNT_MAX : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pulses <= '0;
            r_period <= '0;
            r_ticks  <= '0;
            r_dir    <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pulses <= n_pulses;
            r_period <= n_period;
            r_ticks  <= n_ticks;
            r_dir    <= n_dir;
        end
    end

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of the quotient register as the quotient bits shift in.
    assign shifted = {r_rem, r_quo[CNT_W-1]};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.mul) begin
            n_rem = '0;
            n_quo = NUM;
        end else if (i_cmd.div_step) begin
            if (shifted >= {1'b0, r_divisor}) begin
                n_rem = PROD_W'(shifted - {1'b0, r_divisor});
                n_quo = {r_quo[CNT_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[PROD_W-1:0];
                n_quo = {r_quo[CNT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            r_feed <= i_feed_rate;
        end
        if (i_cmd.mul) begin
            r_divisor <= PROD_W'(r_feed * r_spm);
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick || i_cmd.report || i_cmd.finish) begin
            r_res_strobe <= i_cmd.tick && hit;
            r_res_dir    <= n_dir;
            r_res_busy   <= n_busy;
            r_res_en_low <= ~r_motor_en;
        end
    end

    assign o_step_strobe     = r_res_strobe;
    assign o_direction_level = r_res_dir;
    assign o_moving          = r_res_busy;
    assign o_enable_low      = r_res_en_low;

endmodule

`default_nettype wire

### src/stepper_step_pulse_generator.sv
// Step/direction pulse generator for a stepper motor.
//
// Requests arrive on i_req (valid/ready): mode 0 is a one-microsecond tick,
// mode 1 and 2 start a forward or backward move with a pulse count and a feed
// rate. Every request gives exactly one result on o_res: the step strobe for
// that tick, the direction pin level, the moving flag and the enable pin level.
// The user writes the configuration registers through i_cfg_we/i_cfg_index/
// i_cfg_data only while the block is idle; the block does not enforce this.
//
// A tick or an unused mode is served in the cycle of acceptance; its result is
// valid on the cycle after acceptance and a new request may follow at once. A
// move request holds off the input while it runs: the cycle of acceptance
// latches it, the multiply state forms feed_rate * steps_per_mm, the divide
// state runs a one-bit-per-cycle restoring divider for the step period, and
// the finish state stores it and presents the result. One request is in work
// at a time.
//
// Synchronous reset clears the motion state, loads the register defaults and
// empties the result register. While the receiver stalls, the result is held
// and the next request is taken only in the cycle that the result is taken.
`default_nettype none

module stepper_step_pulse_generator
    import ssp_pkg::*;
#(
    parameter int PERIOD_NUMERATOR = 60000000
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ssp_in_if.sink                     i_req,
    ssp_out_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    ssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_mode      (i_req.mode),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    ssp_datapath #(
        .PERIOD_NUMERATOR (PERIOD_NUMERATOR)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_pulse_count     (i_req.pulse_count),
        .i_feed_rate       (i_req.feed_rate),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_step_strobe     (o_res.step_strobe),
        .o_direction_level (o_res.direction_level),
        .o_moving          (o_res.moving),
        .o_enable_low      (o_res.enable_low)
    );

    assign i_req.ready = in_ready;
    assign o_res.valid = out_valid;

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
    import ssp_pkg::*;

    localparam int PERIOD_NUM = 60000000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TICK_CAP = 300;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PULSE_W-1:0] pulse_count;
        logic [FEED_W-1:0]  feed_rate;
    } step_req_t;

    typedef struct packed {
        logic step_strobe;
        logic direction_level;
        logic moving;
        logic enable_low;
    } motion_res_t;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssp_in_if  req_if ();
    ssp_out_if res_if ();

    stepper_step_pulse_generator #(
        .PERIOD_NUMERATOR(PERIOD_NUM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the motion state and of the registers.
    logic [SPM_W-1:0]   cfg_spm;
    logic               cfg_inv;
    logic               cfg_en;
    logic               m_busy;
    logic [PULSE_W-1:0] m_pulses;
    logic [CNT_W-1:0]   m_period;
    logic [CNT_W-1:0]   m_elapsed;
    logic               m_dir;

    step_req_t   req_backlog[$];
    motion_res_t motion_due[$];
    step_req_t   next_req;
    motion_res_t got_res;
    motion_res_t want_res;

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  hold_left = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    logic req_fire = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] step_period_for(input logic [FEED_W-1:0] fr,
                                                         input logic [SPM_W-1:0] spm);
        logic [PROD_W-1:0] divisor;
        logic [31:0] num;
        divisor = PROD_W'(fr) * PROD_W'(spm);
        num = 32'(PERIOD_NUM) & 32'(CNT_MAX);
        if (divisor == '0)
            return CNT_MAX;
        return CNT_W'(num / 32'(divisor));
    endfunction

    function automatic motion_res_t advance_motion(input step_req_t rq);
        motion_res_t res;
        res.step_strobe = 1'b0;
        case (rq.mode)
            MODE_TICK: begin
                // The timer moves on before it is compared with the period.
                if (m_elapsed != CNT_MAX)
                    m_elapsed = m_elapsed + 1'b1;
                if (m_busy && m_pulses != '0) begin
                    if (m_elapsed >= m_period) begin
                        m_elapsed = '0;
                        res.step_strobe = 1'b1;
                        m_pulses = m_pulses - 1'b1;
                    end
                end else begin
                    m_busy = 1'b0;
                end
            end
            MODE_FWD, MODE_BWD: begin
                m_dir = (rq.mode == MODE_FWD) ^ cfg_inv;
                m_period = step_period_for(rq.feed_rate, cfg_spm);
                m_pulses = rq.pulse_count;
                m_busy = 1'b1;
            end
            default: ;
        endcase
        res.direction_level = m_dir;
        res.moving = m_busy;
        res.enable_low = ~cfg_en;
        return res;
    endfunction

    // Results are checked before this edge's request is predicted, so a result
    // never meets its own expectation in the same step.
    always @(posedge i_clk) begin
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_res = '{res_if.step_strobe, res_if.direction_level, res_if.moving,
                        res_if.enable_low};
            if (motion_due.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                want_res = motion_due.pop_front();
                if (got_res.step_strobe !== want_res.step_strobe) begin
                    $error("step_strobe: expected %0d, got %0d",
                           want_res.step_strobe, got_res.step_strobe);
                    err_cnt++;
                end
                if (got_res.direction_level !== want_res.direction_level) begin
                    $error("direction_level: expected %0d, got %0d",
                           want_res.direction_level, got_res.direction_level);
                    err_cnt++;
                end
                if (got_res.moving !== want_res.moving) begin
                    $error("moving: expected %0d, got %0d",
                           want_res.moving, got_res.moving);
                    err_cnt++;
                end
                if (got_res.enable_low !== want_res.enable_low) begin
                    $error("enable_low: expected %0d, got %0d",
                           want_res.enable_low, got_res.enable_low);
                    err_cnt++;
                end
            end
        end
        if (req_fire)
            motion_due.push_back(advance_motion('{req_if.mode, req_if.pulse_count,
                                                   req_if.feed_rate}));
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || req_fire) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_req = req_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.mode <= next_req.mode;
                    req_if.pulse_count <= next_req.pulse_count;
                    req_if.feed_rate <= next_req.feed_rate;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // The receiver's long hold-off is counted here; the stimulus only asks for it.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL stepper_step_pulse_generator");
            $finish;
        end
    end

    task automatic queue_req(input logic [MODE_W-1:0] mode, input logic [PULSE_W-1:0] pc,
                             input logic [FEED_W-1:0] fr, inout int n);
        req_backlog.push_back('{mode, pc, fr});
        n++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_STEPS_PER_MM:  cfg_spm = val;
            CFG_DIRECTION_INV: cfg_inv = val[0];
            CFG_MOTOR_ENABLE:  cfg_en = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_if.valid || motion_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly whole moves: a move request followed by ticks, up to a cap, to use up its
    // pulses, with the odd cut-short sequence and some free-running noise.
    task automatic queue_random_moves(input int budget);
        int n;
        int target;
        int pulses;
        longint ticks;
        logic [FEED_W-1:0] fr;
        logic [CNT_W-1:0] per;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(99) < 75) begin
                target = $urandom_range(0, 15);
                fr = FEED_W'(((PERIOD_NUM / ((target + 1) * int'(cfg_spm))) > 65535) ?
                             65535 : (PERIOD_NUM / ((target + 1) * int'(cfg_spm))));
                if (fr == '0 || $urandom_range(19) == 0)
                    fr = (fr == '0) ? 16'd1 : '0;
                per = step_period_for(fr, cfg_spm);
                pulses = (per > 200) ? $urandom_range(0, 1) : $urandom_range(0, 12);
                queue_req($urandom_range(0, 1) ? MODE_FWD : MODE_BWD, PULSE_W'(pulses),
                          fr, n);
                ticks = longint'(pulses) * (longint'(per) + 1) + $urandom_range(0, 3);
                if (ticks > TICK_CAP)
                    ticks = TICK_CAP;
                if ($urandom_range(9) == 0)
                    ticks = $urandom_range(0, int'(ticks));
                repeat (int'(ticks)) begin
                    if ($urandom_range(19) == 0)
                        queue_req(MODE_UNUSED, $urandom, 16'($urandom), n);
                    queue_req(MODE_TICK, $urandom, 16'($urandom), n);
                end
            end else begin
                queue_req(MODE_W'($urandom_range(0, 3)), $urandom, 16'($urandom), n);
            end
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_TICK;
        req_if.pulse_count = '0;
        req_if.feed_rate = '0;
        res_if.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STEPS_PER_MM;
        cfg_data = '0;
        cfg_spm = SPM_RESET;
        cfg_inv = 1'b0;
        cfg_en = 1'b1;
        m_busy = 1'b0;
        m_pulses = '0;
        m_period = '0;
        m_elapsed = '0;
        m_dir = 1'b0;
        n = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the register defaults.
        queue_req(MODE_TICK, '0, '0, n);
        queue_req(MODE_UNUSED, '1, '1, n);
        // A move with no pulses is over on the next tick.
        queue_req(MODE_FWD, '0, 16'd500, n);
        queue_req(MODE_TICK, '0, '0, n);
        queue_req(MODE_TICK, '1, '1, n);
        // A zero feed rate saturates the period.
        queue_req(MODE_BWD, '1, '0, n);
        queue_req(MODE_TICK, '0, '0, n);
        queue_req(MODE_FWD, 32'd2, '1, n);
        repeat (17) queue_req(MODE_TICK, '0, '0, n);
        wait_drained();

        write_reg(CFG_STEPS_PER_MM, '1);
        write_reg(CFG_DIRECTION_INV, {15'($urandom), 1'b1});
        write_reg(CFG_MOTOR_ENABLE, {15'($urandom), 1'b0});
        idle_pct = 0;
        stall_pct = 0;
        queue_random_moves(400);
        wait_drained();

        write_reg(CFG_STEPS_PER_MM, 16'd1);
        write_reg(CFG_DIRECTION_INV, {15'($urandom), 1'b0});
        write_reg(CFG_MOTOR_ENABLE, {15'($urandom), 1'b1});
        idle_pct = 69;
        stall_pct = 0;
        queue_random_moves(400);
        wait_drained();

        write_reg(CFG_STEPS_PER_MM, 16'($urandom_range(200, 4000)));
        write_reg(CFG_DIRECTION_INV, 16'd1);
        write_reg(CFG_NO_REG, 16'($urandom));
        idle_pct = 0;
        stall_pct = 69;
        hold_req++;
        queue_random_moves(400);
        wait_drained();

        write_reg(CFG_STEPS_PER_MM, 16'($urandom_range(1, 65535)));
        write_reg(CFG_DIRECTION_INV, 16'($urandom));
        write_reg(CFG_MOTOR_ENABLE, 16'($urandom));
        idle_pct = 10;
        stall_pct = 10;
        queue_random_moves(400);
        wait_drained();

        if (err_cnt == 0 && motion_due.size() == 0)
            $display("PASS stepper_step_pulse_generator");
        else
            $display("FAIL stepper_step_pulse_generator");
        $finish;
    end

endmodule

`default_nettype wire
